@@ design/sbps_pkg.sv @@
// shared types and constants for the strided byte pattern search
// no dependencies

package sbps_pkg;

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int NEEDLE_W       = 64;
    localparam int LENGTH_W       = 4;
    localparam int STRIDE_W       = 8;
    localparam int MATCH_OFFSET_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE        = 2'd2;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic                      valid;
        logic                      found;
        logic [MATCH_OFFSET_W-1:0] offset;
    } t_result;

endpackage

@@ design/sbps_match.sv @@
// window against needle compare for the current effective length
// depends on sbps_pkg

module sbps_match #(
    parameter int NEEDLE_MAX = 8
) (
    input  logic [8*NEEDLE_MAX-1:0]      i_window,
    input  logic [8*NEEDLE_MAX-1:0]      i_needle,
    input  logic [sbps_pkg::LENGTH_W-1:0] i_len,
    output logic                          o_hit
);
    import sbps_pkg::*;

    localparam int IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

    logic [7:0]          win_b [NEEDLE_MAX];
    logic [7:0]          ndl_b [NEEDLE_MAX];
    logic [LENGTH_W-1:0] idx;

    for (genvar g = 0; g < NEEDLE_MAX; g++) begin : g_bytes
        assign win_b[g] = i_window[8*g +: 8];
        assign ndl_b[g] = i_needle[8*g +: 8];
    end

    // needle byte k sits len-1-k bytes back from the newest byte
    always_comb begin
        o_hit = 1'b1;
        idx   = '0;
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            if (LENGTH_W'(k) < i_len) begin
                idx = i_len - LENGTH_W'(1) - LENGTH_W'(k);
                if (win_b[idx[IDX_W-1:0]] != ndl_b[k]) begin
                    o_hit = 1'b0;
                end
            end
        end
    end

endmodule

@@ design/sbps_scan.sv @@
// per-byte scan state: window, byte count, next candidate, done flag
// depends on sbps_pkg and sbps_match

module sbps_scan #(
    parameter int NEEDLE_MAX  = 8,
    parameter int OFFSET_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  sbps_pkg::t_item               i_item,
    input  logic [sbps_pkg::NEEDLE_W-1:0] i_needle,
    input  logic [sbps_pkg::LENGTH_W-1:0] i_length,
    input  logic [sbps_pkg::STRIDE_W-1:0] i_stride,
    output sbps_pkg::t_result             o_res
);
    import sbps_pkg::*;

    localparam int WIN_W = 8 * NEEDLE_MAX;

    logic [WIN_W-1:0]       r_window, n_window;
    logic [OFFSET_BITS-1:0] r_seen, n_seen;
    logic [OFFSET_BITS-1:0] r_cand, n_cand;
    logic                   r_done, n_done;

    logic [LENGTH_W-1:0]    eff_len;
    logic [STRIDE_W-1:0]    eff_stride;
    logic [WIN_W-1:0]       win_next;
    logic [OFFSET_BITS-1:0] seen_next;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS:0]   cand_sum;
    logic                   can_count;
    logic                   cand_hit;
    logic                   hit;

    always_comb begin
        if (i_length == '0) begin
            eff_len = LENGTH_W'(1);
        end else if (i_length > LENGTH_W'(NEEDLE_MAX)) begin
            eff_len = LENGTH_W'(NEEDLE_MAX);
        end else begin
            eff_len = i_length;
        end
        eff_stride = (i_stride == '0) ? STRIDE_W'(1) : i_stride;
    end

    assign win_next  = (r_window << 8) | WIN_W'(i_item.data);
    assign seen_next = r_seen + OFFSET_BITS'(1);
    assign start     = seen_next - OFFSET_BITS'(eff_len);
    assign cand_sum  = {1'b0, r_cand} + (OFFSET_BITS+1)'(eff_stride);
    assign can_count = !r_done && (r_seen != '1);
    assign cand_hit  = (seen_next >= OFFSET_BITS'(eff_len)) && (start == r_cand);

    sbps_match #(
        .NEEDLE_MAX(NEEDLE_MAX)
    ) u_match (
        .i_window(win_next),
        .i_needle(i_needle[WIN_W-1:0]),
        .i_len   (eff_len),
        .o_hit   (hit)
    );

    always_comb begin
        n_window = r_window;
        n_seen   = r_seen;
        n_cand   = r_cand;
        n_done   = r_done;
        o_res    = '0;
        if (i_valid) begin
            if (can_count) begin
                n_window = win_next;
                n_seen   = seen_next;
                if (cand_hit) begin
                    if (hit) begin
                        n_done       = 1'b1;
                        o_res.valid  = 1'b1;
                        o_res.found  = 1'b1;
                        o_res.offset = MATCH_OFFSET_W'(start);
                    end else begin
                        n_cand = cand_sum[OFFSET_BITS] ? '1 : cand_sum[OFFSET_BITS-1:0];
                    end
                end
            end
            if (i_item.last) begin
                if (!o_res.valid && !r_done) begin
                    o_res.valid = 1'b1;
                end
                n_seen = '0;
                n_cand = '0;
                n_done = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_cand <= '0;
            r_done <= 1'b0;
        end else begin
            r_seen <= n_seen;
            r_cand <= n_cand;
            r_done <= n_done;
        end
    end

    // stale window bytes are never compared: a check needs len counted bytes
    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

    a_found_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_res.found && !i_item.last) |=> r_done)
        else $error("match reported without setting done");

    a_no_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_done) |-> !o_res.found)
        else $error("second match reported in one haystack");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_item.last) |=> (r_seen == '0 && r_cand == '0 && !r_done))
        else $error("state not cleared after last byte");

    a_cand_not_passed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_done && r_cand != '1 && r_seen != '1 && r_seen >= OFFSET_BITS'(eff_len)
         && $stable(eff_len)) |-> (r_seen - OFFSET_BITS'(eff_len) <= r_cand))
        else $error("candidate start skipped");

endmodule

@@ design/strided_byte_pattern_search.sv @@
// strided byte pattern search: each input byte is held in the input register,
// then the scan writes its result to the result register; one byte per cycle
// sustained, stalling only while the result register holds an untaken result
// synchronous active-low reset clears the scan state, empties both registers
// and loads needle 0, needle length 1, stride 1; depends on sbps_pkg, sbps_scan
module strided_byte_pattern_search #(
    parameter int NEEDLE_MAX  = 8,
    parameter int OFFSET_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sbps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // data_byte
    input  logic                            i_s_axis_tlast,   // last_byte
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [31:0]                     o_m_axis_tdata,   // match_offset
    output logic                            o_m_axis_tuser    // found
);
    import sbps_pkg::*;

    logic [NEEDLE_W-1:0] r_needle;
    logic [LENGTH_W-1:0] r_length;
    logic [STRIDE_W-1:0] r_stride;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    logic    advance;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle <= '0;
            r_length <= LENGTH_W'(1);
            r_stride <= STRIDE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NEEDLE_BYTES:  r_needle <= i_cfg_data[NEEDLE_W-1:0];
                CFG_NEEDLE_LENGTH: r_length <= i_cfg_data[LENGTH_W-1:0];
                CFG_STRIDE:        r_stride <= i_cfg_data[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.data <= i_s_axis_tdata;
            r_in.last <= i_s_axis_tlast;
        end
    end

    sbps_scan #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_item  (r_in),
        .i_needle(r_needle),
        .i_length(r_length),
        .i_stride(r_stride),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && (!r_out_valid || i_m_axis_tready)) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.offset;
    assign o_m_axis_tuser  = r_out.found;

endmodule

@@ tb/tb_strided_byte_pattern_search.sv @@
// testbench for strided_byte_pattern_search: drives haystack byte streams and
// register writes, predicts each found / not-found result and checks it on the
// result stream; depends on sbps_pkg and strided_byte_pattern_search
`timescale 1ns / 100ps

module tb_strided_byte_pattern_search;

    import sbps_pkg::*;

    localparam int          NEEDLE_MAX    = 8;
    localparam longint      OFFSET_MAX    = 64'hFFFF_FFFF;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES  = 4;

    typedef struct {
        logic                      found;
        logic [MATCH_OFFSET_W-1:0] offset;
    } t_search_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;    // data_byte
    logic                  i_s_axis_tlast = 1'b0;  // last_byte
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [31:0]           o_m_axis_tdata;         // match_offset
    logic                  o_m_axis_tuser;         // found

    // search model state and registers
    logic [NEEDLE_W-1:0]   cfg_needle = '0;
    logic [LENGTH_W-1:0]   cfg_len = 4'd1;
    logic [STRIDE_W-1:0]   cfg_stride = 8'd1;
    logic [63:0]           hay_window = '0;
    longint unsigned       hay_count = 0;
    longint unsigned       next_start = 0;
    bit                    hit_reported = 1'b0;

    t_search_result        awaited_results[$];
    int unsigned           mismatch_count = 0;
    int unsigned           bytes_sent = 0;
    int unsigned           sender_gap_pct = 0;
    int unsigned           sink_stall_pct = 0;
    int unsigned           sink_hold = 0;
    int unsigned           quiet_cycles = 0;

    strided_byte_pattern_search #(
        .NEEDLE_MAX  (NEEDLE_MAX),
        .OFFSET_BITS (32)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_len();
        if (cfg_len == 0) begin
            return 1;
        end
        if (cfg_len > NEEDLE_MAX) begin
            return NEEDLE_MAX;
        end
        return cfg_len;
    endfunction

    function automatic int unsigned eff_stride();
        return (cfg_stride == 0) ? 1 : cfg_stride;
    endfunction

    task automatic search_byte(input logic [7:0] data, input logic last);
        longint unsigned n;
        longint unsigned start;
        bit              hit;
        bit              same;
        hit = 1'b0;
        if (!hit_reported && hay_count < OFFSET_MAX) begin
            n = eff_len();
            hay_window = {hay_window[55:0], data};
            hay_count++;
            if (hay_count >= n) begin
                start = hay_count - n;
                if (start == next_start) begin
                    same = 1'b1;
                    for (int k = 0; k < n; k++) begin
                        if (hay_window[8*(n-1-k) +: 8] != cfg_needle[8*k +: 8]) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        hit_reported = 1'b1;
                        hit = 1'b1;
                        awaited_results.push_back('{1'b1, start[31:0]});
                    end else if (next_start > OFFSET_MAX - eff_stride()) begin
                        next_start = OFFSET_MAX;
                    end else begin
                        next_start = next_start + eff_stride();
                    end
                end
            end
        end
        if (last) begin
            if (!hit && !hit_reported) begin
                awaited_results.push_back('{1'b0, 32'd0});
            end
            hay_window = '0;
            hay_count = 0;
            next_start = 0;
            hit_reported = 1'b0;
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        search_byte(data, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_haystack(input int unsigned len, input int plant);
        logic [7:0]  hay[];
        int unsigned pick;
        hay = new[len];
        foreach (hay[i]) begin
            pick = $urandom_range(NEEDLE_MAX - 1);
            hay[i] = $urandom_range(1) ? cfg_needle[8*pick +: 8] : 8'($urandom_range(255));
        end
        if (plant >= 0) begin
            for (int j = 0; j < eff_len(); j++) begin
                hay[plant + j] = cfg_needle[8*j +: 8];
            end
        end
        foreach (hay[i]) begin
            send_byte(hay[i], i == len - 1);
        end
    endtask

    // sender pauses until every awaited result is out and the pipe is empty
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_NEEDLE_BYTES:  cfg_needle = value;
            CFG_NEEDLE_LENGTH: cfg_len = value[LENGTH_W-1:0];
            CFG_STRIDE:        cfg_stride = value[STRIDE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_byte(8'h05, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h07, 1'b1);
        send_byte(8'hFF, 1'b1);
        settle();
    endtask

    task automatic test_extremes();
        write_reg(CFG_NEEDLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_NEEDLE_LENGTH, 64'd8);
        write_reg(CFG_STRIDE, 64'd8);
        // haystack shorter than the needle
        repeat (2) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // match completes on the last byte
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();
        write_reg(CFG_STRIDE, 64'd255);
        write_reg(CFG_NEEDLE_LENGTH, 64'd15);
        send_haystack(8, 0);
        settle();
    endtask

    task automatic test_zero_length_and_stride();
        write_reg(CFG_NEEDLE_BYTES, 64'h0000_0000_0000_00A5);
        write_reg(CFG_NEEDLE_LENGTH, 64'd0);
        write_reg(CFG_STRIDE, 64'd0);
        // match then swallowed bytes, last after a match gives nothing
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();
    endtask

    task automatic test_config_mid_haystack();
        write_reg(CFG_NEEDLE_BYTES, 64'h0000_0000_0000_3412);
        write_reg(CFG_NEEDLE_LENGTH, 64'd2);
        write_reg(CFG_STRIDE, 64'd4);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        settle();
        write_reg(CFG_STRIDE, 64'd1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        settle();
    endtask

    task automatic test_result_backpressure();
        write_reg(CFG_NEEDLE_BYTES, 64'h0000_0000_0000_00C3);
        write_reg(CFG_NEEDLE_LENGTH, 64'd1);
        write_reg(CFG_STRIDE, 64'd1);
        sender_gap_pct = 0;
        sink_stall_pct = 0;
        sink_hold = 300;
        for (int i = 0; i < 24; i++) begin
            send_byte(8'($urandom_range(1) ? 8'hC3 : 8'($urandom_range(255))), 1'b0);
            send_byte(8'($urandom_range(255)), 1'b1);
        end
        settle();
    endtask

    task automatic test_random_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int unsigned byte_budget);
        int unsigned target;
        int unsigned len;
        int unsigned n;
        int          plant;
        sender_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        target = bytes_sent + byte_budget;
        while (bytes_sent < target) begin
            settle();
            if ($urandom_range(2) == 0) begin
                write_reg(CFG_NEEDLE_BYTES, {$urandom_range(1) ? 32'h0 : 32'($urandom), 32'($urandom)});
            end else begin
                write_reg(CFG_NEEDLE_BYTES, {$urandom, $urandom});
            end
            write_reg(CFG_NEEDLE_LENGTH, 64'($urandom_range(3) == 0 ? $urandom_range(15)
                                                                    : $urandom_range(1, NEEDLE_MAX)));
            case ($urandom_range(5))
                0:       write_reg(CFG_STRIDE, 64'd1);
                1:       write_reg(CFG_STRIDE, 64'(eff_len()));
                2:       write_reg(CFG_STRIDE, 64'd255);
                3:       write_reg(CFG_STRIDE, 64'd0);
                default: write_reg(CFG_STRIDE, 64'($urandom_range(1, 12)));
            endcase
            n = eff_len();
            repeat ($urandom_range(1, 6)) begin
                len = ($urandom_range(24) == 0) ? $urandom_range(256, 520) : $urandom_range(1, 40);
                plant = -1;
                if (len >= n) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5:
                            plant = $urandom_range((len - n) / eff_stride()) * eff_stride();
                        6, 7:
                            plant = $urandom_range(len - n);
                        default: ;
                    endcase
                end
                send_haystack(len, plant);
            end
        end
        settle();
    endtask

    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            i_m_axis_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_search_result exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result found=%0d offset=%0d", $time,
                         o_m_axis_tuser, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                exp_r = awaited_results.pop_front();
                if (o_m_axis_tuser !== exp_r.found) begin
                    $display("%0t: found mismatch expected %0d actual %0d", $time,
                             exp_r.found, o_m_axis_tuser);
                    mismatch_count++;
                end
                if (o_m_axis_tdata !== exp_r.offset) begin
                    $display("%0t: match_offset mismatch expected %0d actual %0d", $time,
                             exp_r.offset, o_m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_values();
        test_extremes();
        test_zero_length_and_stride();
        test_config_mid_haystack();
        test_result_backpressure();
        test_random_phase(10, 77, 350);
        test_random_phase(77, 10, 350);
        test_random_phase(0, 0, 350);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/sbps_pkg.sv
design/sbps_match.sv
design/sbps_scan.sv
design/strided_byte_pattern_search.sv
tb/tb_strided_byte_pattern_search.sv
